// ----- rtl/rsi_pkg.sv -----
`default_nettype none
package rsi_pkg;

  typedef enum logic [1:0] {
    REL_INSIDE  = 2'd0,
    REL_OUTSIDE = 2'd1,
    REL_SURFACE = 2'd2
  } rel_t;

  typedef enum logic [1:0] {
    HIT_NONE    = 2'd0,
    HIT_BEHIND  = 2'd1,
    HIT_TANGENT = 2'd2,
    HIT_CROSS   = 2'd3
  } hit_t;

  localparam logic [1:0] REG_RADIUS   = 2'd0;
  localparam logic [1:0] REG_CENTRE_X = 2'd1;
  localparam logic [1:0] REG_CENTRE_Y = 2'd2;
  localparam logic [1:0] REG_CENTRE_Z = 2'd3;

  localparam int unsigned USER_W = 4;

endpackage
`default_nettype wire

// ----- rtl/ray_sphere_intersection.sv -----
// Ray / sphere intersection, fully pipelined.
// Input stream: one request per ray, in_tdata = pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
// (lowest bits first), position Q.FRAC_BITS, direction Q2.(COORD_WIDTH-2).
// Output stream: one result per request, in order. out_tuser holds relation and hit
// kind, out_tdata holds hit distance and hit point.
// Sphere centre and radius come from the write port (index 0 radius, 1..3 centre
// x/y/z); write them only while no request is in flight.
// Throughput: one request per cycle while the output is not stalled. Most of the pipeline
// is the square root, which resolves one root bit per stage.
// The pipeline advances as a whole; while a result is held on a stalled output, all
// stages and in_tready hold, so nothing is lost or repeated. Bubbles travel with
// their valid bits.
// Reset (synchronous, rst_n low) empties the pipeline, sets radius to 1.0 and the
// centre to the origin.
`default_nettype none
module ray_sphere_intersection #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    cfg_wr_en,
  input  wire [1:0]                              cfg_addr,
  input  wire [COORD_WIDTH-1:0]                  cfg_wdata,
  input  wire                                    in_tvalid,
  output logic                                   in_tready,
  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, zero pad
  input  wire [((6*COORD_WIDTH+7)/8)*8-1:0]      in_tdata,
  output logic                                   out_tvalid,
  input  wire                                    out_tready,
  // hit_distance, hit_x, hit_y, hit_z, zero pad
  output logic [((4*COORD_WIDTH-1+7)/8)*8-1:0]   out_tdata,
  // relation, hit_kind
  output logic [rsi_pkg::USER_W-1:0]             out_tuser
);

  localparam int W     = COORD_WIDTH;
  localparam int KW    = W + 1;
  localparam int SQW   = 2 * KW;
  localparam int KDW   = KW + W;
  localparam int R2W   = 2 * (W - 1);
  localparam int QW    = 2 * W + 4;
  localparam int DTW   = 2 * W + 3;
  localparam int BW    = W + 5;
  localparam int DW    = 2 * BW;
  localparam int RB    = BW;
  localparam int SW    = W + 7;
  localparam int DSW   = W + 6;
  localparam int PRW   = W + DSW + 1;
  localparam int HW    = W + 10;
  localparam int OUT_TW = ((4*W-1+7)/8)*8;

  typedef struct packed {
    logic signed [BW-1:0] b;
    logic                 neg;
    logic                 zero;
    rsi_pkg::rel_t        rel;
    logic [3*W-1:0]       p;
    logic [3*W-1:0]       d;
  } side_t;

  logic [W-2:0]          radius_r;
  logic signed [W-1:0]   centre_r [3];

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= (W-1)'(1) << FRAC_BITS;
      centre_r[0] <= '0;
      centre_r[1] <= '0;
      centre_r[2] <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        rsi_pkg::REG_RADIUS:   radius_r    <= cfg_wdata[W-2:0];
        rsi_pkg::REG_CENTRE_X: centre_r[0] <= cfg_wdata;
        rsi_pkg::REG_CENTRE_Y: centre_r[1] <= cfg_wdata;
        rsi_pkg::REG_CENTRE_Z: centre_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic [RB-1:0] vs_r;
  logic out_tvalid_r;

  // stage 1: offset from centre
  logic signed [W-1:0]  p1_r [3];
  logic signed [W-1:0]  d1_r [3];
  logic signed [KW-1:0] k1_r [3];
  logic [W-2:0]         r1_r;
  // stage 2: products
  logic signed [W-1:0]   p2_r [3];
  logic signed [W-1:0]   d2_r [3];
  logic signed [SQW-1:0] sq2_r [3];
  logic signed [KDW-1:0] kd2_r [3];
  logic [R2W-1:0]        r2_r;
  // stage 3: q, b
  logic signed [W-1:0]  p3_r [3];
  logic signed [W-1:0]  d3_r [3];
  logic signed [QW-1:0] q3_r;
  logic signed [BW-1:0] b3_r;
  rsi_pkg::rel_t        rel3_r;
  // stage 4: b squared
  logic signed [W-1:0]  p4_r [3];
  logic signed [W-1:0]  d4_r [3];
  logic signed [QW-1:0] q4_r;
  logic signed [BW-1:0] b4_r;
  logic signed [DW-1:0] bb4_r;
  rsi_pkg::rel_t        rel4_r;
  // stage 5: discriminant
  logic [DW-1:0] rad5_r;
  side_t         side5_r;
  // root stages
  logic [RB+1:0] rem_r  [RB];
  logic [RB-1:0] root_r [RB];
  logic [DW-1:0] rad_r  [RB];
  side_t         side_r [RB];
  // stage 6: roots chosen
  logic [DSW-1:0]      dist6_r;
  rsi_pkg::hit_t       kind6_r;
  rsi_pkg::rel_t       rel6_r;
  logic signed [W-1:0] p6_r [3];
  logic signed [W-1:0] d6_r [3];
  // stage 7: hit products
  logic signed [PRW-1:0] prod7_r [3];
  logic signed [W-1:0]   p7_r [3];
  logic [W-2:0]          dsat7_r;
  rsi_pkg::hit_t         kind7_r;
  rsi_pkg::rel_t         rel7_r;
  // output
  logic [OUT_TW-1:0]          out_tdata_r;
  logic [rsi_pkg::USER_W-1:0] out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
      vs_r <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      vs_r <= {vs_r[RB-2:0], v5_r};
      v6_r <= vs_r[RB-1];
      v7_r <= v6_r;
      out_tvalid_r <= v7_r;
    end
  end

  // stage 1..4
  logic signed [QW-1:0]  kk3;
  logic signed [DTW-1:0] dot3, dotr3;
  logic signed [QW-1:0]  q3;
  always_comb begin
    kk3   = QW'(sq2_r[0]) + QW'(sq2_r[1]) + QW'(sq2_r[2]);
    q3    = kk3 - QW'(r2_r);
    dot3  = DTW'(kd2_r[0]) + DTW'(kd2_r[1]) + DTW'(kd2_r[2]);
    dotr3 = dot3 + (DTW'(1) << (W - 3));
  end

  logic signed [DW-1:0] disc5;
  always_comb disc5 = bb4_r - DW'(q4_r);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i]  <= in_tdata[W*i +: W];
        d1_r[i]  <= in_tdata[W*(i+3) +: W];
        k1_r[i]  <= {in_tdata[W*i+W-1], in_tdata[W*i +: W]}
                    - {centre_r[i][W-1], centre_r[i]};
        p2_r[i]  <= p1_r[i];
        d2_r[i]  <= d1_r[i];
        sq2_r[i] <= k1_r[i] * k1_r[i];
        kd2_r[i] <= k1_r[i] * d1_r[i];
        p3_r[i]  <= p2_r[i];
        d3_r[i]  <= d2_r[i];
        p4_r[i]  <= p3_r[i];
        d4_r[i]  <= d3_r[i];
      end
      r1_r <= radius_r;
      r2_r <= r1_r * r1_r;
      q3_r <= q3;
      b3_r <= BW'(dotr3 >>> (W - 2));
      if (q3[QW-1])
        rel3_r <= rsi_pkg::REL_INSIDE;
      else if (q3 == '0)
        rel3_r <= rsi_pkg::REL_SURFACE;
      else
        rel3_r <= rsi_pkg::REL_OUTSIDE;
      q4_r   <= q3_r;
      b4_r   <= b3_r;
      bb4_r  <= b3_r * b3_r;
      rel4_r <= rel3_r;
      rad5_r       <= disc5[DW-1] ? '0 : disc5;
      side5_r.b    <= b4_r;
      side5_r.neg  <= disc5[DW-1];
      side5_r.zero <= (disc5 == '0);
      side5_r.rel  <= rel4_r;
      side5_r.p    <= {p4_r[2], p4_r[1], p4_r[0]};
      side5_r.d    <= {d4_r[2], d4_r[1], d4_r[0]};
    end
  end

  // integer root, one bit per stage
  genvar s;
  generate
    for (s = 0; s < RB; s++) begin : g_root
      logic [RB+1:0] rem_in, rem_sh, trial;
      logic [RB-1:0] root_in;
      logic [DW-1:0] rad_in;
      side_t         side_in;
      if (s == 0) begin : g_first
        assign rem_in  = '0;
        assign root_in = '0;
        assign rad_in  = rad5_r;
        assign side_in = side5_r;
      end else begin : g_next
        assign rem_in  = rem_r[s-1];
        assign root_in = root_r[s-1];
        assign rad_in  = rad_r[s-1];
        assign side_in = side_r[s-1];
      end
      assign rem_sh = {rem_in[RB-1:0], rad_in[DW-1 -: 2]};
      assign trial  = {root_in, 2'b01};
      always_ff @(posedge clk) begin
        if (en) begin
          if (rem_sh >= trial) begin
            rem_r[s]  <= rem_sh - trial;
            root_r[s] <= {root_in[RB-2:0], 1'b1};
          end else begin
            rem_r[s]  <= rem_sh;
            root_r[s] <= {root_in[RB-2:0], 1'b0};
          end
          rad_r[s]  <= rad_in << 2;
          side_r[s] <= side_in;
        end
      end
    end
  endgenerate

  // stage 6: nearest positive root
  side_t                side6;
  logic signed [SW-1:0] nb6, s1_6, s2_6;
  logic                 s1pos, s2pos;
  always_comb begin
    side6 = side_r[RB-1];
    nb6   = -SW'(side6.b);
    s2_6  = nb6 - SW'({1'b0, root_r[RB-1]});
    s1_6  = nb6 + SW'({1'b0, root_r[RB-1]});
    s2pos = !s2_6[SW-1] && (s2_6 != '0);
    s1pos = !s1_6[SW-1] && (s1_6 != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rel6_r <= side6.rel;
      for (int i = 0; i < 3; i++) begin
        p6_r[i] <= side6.p[W*i +: W];
        d6_r[i] <= side6.d[W*i +: W];
      end
      if (side6.neg) begin
        kind6_r <= rsi_pkg::HIT_NONE;
        dist6_r <= '0;
      end else if (s2pos) begin
        kind6_r <= side6.zero ? rsi_pkg::HIT_TANGENT : rsi_pkg::HIT_CROSS;
        dist6_r <= s2_6[DSW-1:0];
      end else if (s1pos) begin
        kind6_r <= side6.zero ? rsi_pkg::HIT_TANGENT : rsi_pkg::HIT_CROSS;
        dist6_r <= s1_6[DSW-1:0];
      end else begin
        kind6_r <= rsi_pkg::HIT_BEHIND;
        dist6_r <= '0;
      end
    end
  end

  // stage 7: direction times distance
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod7_r[i] <= d6_r[i] * $signed({1'b0, dist6_r});
        p7_r[i]    <= p6_r[i];
      end
      dsat7_r <= (dist6_r[DSW-1:W-1] != '0) ? {(W-1){1'b1}} : dist6_r[W-2:0];
      kind7_r <= kind6_r;
      rel7_r  <= rel6_r;
    end
  end

  // stage 8: round, add position, saturate
  logic signed [PRW-1:0] pr8 [3];
  logic signed [HW-1:0]  h8 [3];
  logic [W-1:0]          hs8 [3];
  logic                  hit8;
  logic [OUT_TW-1:0]     out_tdata_nxt;
  always_comb begin
    hit8 = (kind7_r == rsi_pkg::HIT_TANGENT) || (kind7_r == rsi_pkg::HIT_CROSS);
    for (int i = 0; i < 3; i++) begin
      pr8[i] = (prod7_r[i] + (PRW'(1) << (W - 3))) >>> (W - 2);
      h8[i]  = HW'(pr8[i]) + HW'(p7_r[i]);
      if (!h8[i][HW-1] && (h8[i][HW-2:W-1] != '0))
        hs8[i] = {1'b0, {(W-1){1'b1}}};
      else if (h8[i][HW-1] && (h8[i][HW-2:W-1] != {(HW-W){1'b1}}))
        hs8[i] = {1'b1, {(W-1){1'b0}}};
      else
        hs8[i] = h8[i][W-1:0];
    end
    out_tdata_nxt = '0;
    if (hit8) begin
      out_tdata_nxt[W-2:0]         = dsat7_r;
      out_tdata_nxt[W-1 +: W]      = hs8[0];
      out_tdata_nxt[2*W-1 +: W]    = hs8[1];
      out_tdata_nxt[3*W-1 +: W]    = hs8[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= {kind7_r, rel7_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
`default_nettype wire

// ----- rtl/rsi_checker.sv -----
`default_nettype none
module rsi_checker #(
  parameter int COORD_WIDTH = 32
) (
  input wire                                  clk,
  input wire                                  rst_n,
  input wire                                  in_tready,
  input wire                                  out_tvalid,
  input wire                                  out_tready,
  input wire [((4*COORD_WIDTH-1+7)/8)*8-1:0]  out_tdata,
  input wire [rsi_pkg::USER_W-1:0]            out_tuser
);

  logic hit, miss;
  assign hit  = (out_tuser[3:2] == rsi_pkg::HIT_TANGENT)
             || (out_tuser[3:2] == rsi_pkg::HIT_CROSS);
  assign miss = (out_tuser[3:2] == rsi_pkg::HIT_NONE)
             || (out_tuser[3:2] == rsi_pkg::HIT_BEHIND);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && miss |-> out_tdata == '0)
    else $error("hit fields set without a hit");

  a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && hit |-> out_tdata[COORD_WIDTH-2:0] != '0)
    else $error("hit with zero distance");

  a_tangent_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[3:2] == rsi_pkg::HIT_TANGENT)
      |-> out_tuser[1:0] != rsi_pkg::REL_INSIDE)
    else $error("tangent from inside the sphere");

endmodule

bind ray_sphere_intersection rsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
